>>> hw/rtl/gem_pkg.sv
// ----------------------------------------------------------------------------
// gem_pkg
// Shared types and constants of the gradient edge magnitude core.
// ----------------------------------------------------------------------------
package gem_pkg;

    typedef enum logic [1:0] {
        OP_ROBERTS = 2'd0,
        OP_PREWITT = 2'd1,
        OP_SOBEL   = 2'd2
    } op_mode_t;

    typedef enum logic [1:0] {
        CFG_OPERATOR_MODE = 2'd0,
        CFG_IMAGE_WIDTH   = 2'd1,
        CFG_IMAGE_HEIGHT  = 2'd2
    } cfg_index_t;

    localparam int unsigned WIDTH_REG_W  = 11;
    localparam int unsigned HEIGHT_REG_W = 12;
    localparam int unsigned CFG_DATA_W   = 12;

    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 12'd480;
    localparam logic [7:0]              EDGE_MAX     = 8'd255;

    // Per-item flags carried from the input side to the result side.
    typedef struct packed {
        logic pos_valid;
        logic interior;
        logic last;
    } item_flags_t;

endpackage

>>> hw/rtl/gradient_edge_magnitude_core.sv
// ----------------------------------------------------------------------------
// gradient_edge_magnitude_core
// 3x3 gradient edge magnitude (Roberts / Prewitt / Sobel) on a raster stream.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while the output is not stalled and returns one
// result per pixel. Each result passes through the registered read of the
// line store memory and then the result register; the window and kernel
// arithmetic sit between them. The result for a pixel describes the
// window centred one row up and one column left.
// Image border centres give zero; the last row and column are not produced.
// Configuration must be written while the core is idle.
module gradient_edge_magnitude_core #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [1:0]                      cfg_index,
    input  logic [gem_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [7:0]                      pixel,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [7:0]                      edge_value,
    output logic                            position_valid,
    output logic                            frame_last
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int XW = (CW + 1 > gem_pkg::WIDTH_REG_W) ? CW + 1 : gem_pkg::WIDTH_REG_W;
    localparam int HW = gem_pkg::HEIGHT_REG_W;

    // configuration
    gem_pkg::op_mode_t  op_mode_reg;
    logic [gem_pkg::WIDTH_REG_W-1:0] width_reg;
    logic [HW-1:0]      height_reg;

    // position counters
    logic [CW-1:0]      col_reg, col_next;
    logic [HW-1:0]      row_reg, row_next;

    // stage 1
    logic               s1_valid_reg;
    logic [7:0]         s1_px_reg;
    logic [CW-1:0]      s1_idx_reg;
    gem_pkg::item_flags_t s1_flags_reg, flags_next;

    // line store: {upper, middle}
    logic [15:0]        line_mem [MAX_WIDTH];
    logic [15:0]        rd_reg;
    logic               byp_reg;
    logic [15:0]        byp_data_reg;
    logic [15:0]        rd_pair, wr_data;

    // window
    logic [7:0]         win_reg [9];
    logic [7:0]         win_next [9];

    // output
    logic               out_valid_reg;
    logic [7:0]         edge_reg;
    logic               pos_valid_reg;
    logic               last_reg;

    logic               in_fire, s1_adv;
    logic [XW-1:0]      width_x, w_eff, col_x;
    logic [HW-1:0]      h_eff;
    logic [HW:0]        row_inc;
    logic               row_end, frame_end;
    logic [7:0]         edge_next;

    assign cfg_ready = 1'b1;
    assign s1_adv    = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || s1_adv;
    assign in_fire   = in_valid && in_ready;

    // ------------------------------------------------------------ config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_mode_reg <= gem_pkg::OP_ROBERTS;
            width_reg   <= gem_pkg::WIDTH_RESET;
            height_reg  <= gem_pkg::HEIGHT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                gem_pkg::CFG_OPERATOR_MODE:
                    op_mode_reg <= gem_pkg::op_mode_t'(cfg_data[1:0]);
                gem_pkg::CFG_IMAGE_WIDTH:
                    width_reg <= cfg_data[gem_pkg::WIDTH_REG_W-1:0];
                gem_pkg::CFG_IMAGE_HEIGHT:
                    height_reg <= cfg_data[HW-1:0];
                default:
                    ;
            endcase
        end
    end

    // ------------------------------------------------------------ position
    always_comb
    begin
        width_x = XW'(width_reg);
        if (width_x == '0)
            w_eff = XW'(1);
        else if (width_x > XW'(MAX_WIDTH))
            w_eff = XW'(MAX_WIDTH);
        else
            w_eff = width_x;
        h_eff   = (height_reg == '0) ? HW'(1) : height_reg;
        col_x   = XW'(col_reg);
        row_inc = {1'b0, row_reg} + (HW+1)'(1);

        row_end   = (col_x + XW'(1)) >= w_eff;
        frame_end = row_end && (row_inc >= {1'b0, h_eff});

        flags_next.pos_valid = (row_reg != '0) && (row_reg <= h_eff)
                            && (col_reg != '0) && (col_x <= w_eff);
        flags_next.interior  = (row_reg >= HW'(2)) && (row_reg < h_eff)
                            && (col_reg >= CW'(2)) && (col_x < w_eff);
        flags_next.last      = frame_end;

        col_next = col_reg;
        row_next = row_reg;
        if (row_end)
        begin
            col_next = '0;
            row_next = frame_end ? '0 : row_inc[HW-1:0];
        end
        else
        begin
            col_next = col_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (in_fire)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_px_reg    <= pixel;
            s1_idx_reg   <= col_reg;
            s1_flags_reg <= flags_next;
        end
    end

    // ------------------------------------------------------------ line store
    assign rd_pair = byp_reg ? byp_data_reg : rd_reg;
    assign wr_data = {rd_pair[7:0], s1_px_reg};

    always_ff @(posedge clk)
    begin
        if (s1_adv)
            line_mem[s1_idx_reg] <= wr_data;
        if (in_fire)
        begin
            rd_reg       <= line_mem[col_reg];
            byp_reg      <= s1_adv && (s1_idx_reg == col_reg);
            byp_data_reg <= wr_data;
        end
    end

    // ------------------------------------------------------------ window
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            win_next[i*3+0] = win_reg[i*3+1];
            win_next[i*3+1] = win_reg[i*3+2];
        end
        win_next[2] = rd_pair[15:8];
        win_next[5] = rd_pair[7:0];
        win_next[8] = s1_px_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
                win_reg[i] <= '0;
        end
        else if (s1_adv)
        begin
            for (int i = 0; i < 9; i++)
                win_reg[i] <= win_next[i];
        end
    end

    // ------------------------------------------------------------ kernels
    logic [9:0]         pa, pb, qa, qb;
    logic signed [10:0] gx, gy;
    logic [9:0]         ax, ay;
    logic [10:0]        mag;

    always_comb
    begin
        unique case (op_mode_reg)
            gem_pkg::OP_ROBERTS:
            begin
                pa = 10'(win_next[0]);
                pb = 10'(win_next[4]);
                qa = 10'(win_next[1]);
                qb = 10'(win_next[3]);
            end
            gem_pkg::OP_PREWITT:
            begin
                pa = 10'(win_next[0]) + 10'(win_next[3]) + 10'(win_next[6]);
                pb = 10'(win_next[2]) + 10'(win_next[5]) + 10'(win_next[8]);
                qa = 10'(win_next[0]) + 10'(win_next[1]) + 10'(win_next[2]);
                qb = 10'(win_next[6]) + 10'(win_next[7]) + 10'(win_next[8]);
            end
            default:
            begin
                pa = 10'(win_next[0]) + {1'b0, win_next[3], 1'b0} + 10'(win_next[6]);
                pb = 10'(win_next[2]) + {1'b0, win_next[5], 1'b0} + 10'(win_next[8]);
                qa = 10'(win_next[0]) + {1'b0, win_next[1], 1'b0} + 10'(win_next[2]);
                qb = 10'(win_next[6]) + {1'b0, win_next[7], 1'b0} + 10'(win_next[8]);
            end
        endcase

        gx  = $signed({1'b0, pa}) - $signed({1'b0, pb});
        gy  = $signed({1'b0, qa}) - $signed({1'b0, qb});
        ax  = gx[10] ? 10'(-gx) : gx[9:0];
        ay  = gy[10] ? 10'(-gy) : gy[9:0];
        mag = {1'b0, ax} + {1'b0, ay};

        if (!s1_flags_reg.interior)
            edge_next = '0;
        else if (mag > 11'(gem_pkg::EDGE_MAX))
            edge_next = gem_pkg::EDGE_MAX;
        else
            edge_next = mag[7:0];
    end

    // ------------------------------------------------------------ output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_adv)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            edge_reg      <= edge_next;
            pos_valid_reg <= s1_flags_reg.pos_valid;
            last_reg      <= s1_flags_reg.last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign edge_value     = edge_reg;
    assign position_valid = pos_valid_reg;
    assign frame_last     = last_reg;

endmodule

>>> tb/sv/gem_edge_checker.sv
// ----------------------------------------------------------------------------
// gem_edge_checker
// Watches the config, pixel and result channels of the edge magnitude core.
// Each accepted pixel steps a local copy of the line stores, the 3x3 window
// and the raster position to predict its result. Each accepted result is
// compared against the oldest prediction. Mismatches, unexpected results
// and predictions still waiting are summed into fail_count.
// ----------------------------------------------------------------------------
module gem_edge_checker #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [1:0]                     cfg_index,
    input  logic [gem_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic [7:0]                     pixel,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic [7:0]                     edge_value,
    input  logic                           position_valid,
    input  logic                           frame_last,
    output int                             fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] edge_val;
        logic       pos_valid;
        logic       last;
    } edge_result_t;

    logic [1:0]                       mode_reg;
    logic [gem_pkg::WIDTH_REG_W-1:0]  width_reg;
    logic [gem_pkg::HEIGHT_REG_W-1:0] height_reg;

    logic [7:0] upper_row [MAX_WIDTH];
    logic [7:0] middle_row [MAX_WIDTH];
    int         win_px [9];
    int         next_col;
    int         next_row;

    edge_result_t pending_edges[$];
    int           mismatch_cnt = 0;
    int           result_idx = 0;

    initial fail_count = 0;

    function automatic edge_result_t predict_edge(input logic [7:0] px);
        int           w;
        int           h;
        int           c;
        int           r;
        int           idx;
        int           gx;
        int           gy;
        int           k;
        int           mag;
        logic [7:0]   up;
        logic [7:0]   mid;
        logic         pos_ok;
        logic         inner;
        logic         row_end;
        edge_result_t res;

        w = int'(width_reg);
        if (w < 1) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        h = int'(height_reg);
        if (h < 1) h = 1;
        c = next_col;
        r = next_row;

        idx = c % MAX_WIDTH;
        up = upper_row[idx];
        mid = middle_row[idx];
        upper_row[idx] = mid;
        middle_row[idx] = px;

        for (int i = 0; i < 3; i++)
        begin
            win_px[i*3]   = win_px[i*3+1];
            win_px[i*3+1] = win_px[i*3+2];
        end
        win_px[2] = int'(up);
        win_px[5] = int'(mid);
        win_px[8] = int'(px);

        pos_ok = (r >= 1) && (c >= 1) && (r - 1 < h) && (c - 1 < w);
        inner  = pos_ok && (r >= 2) && (c >= 2) && (r - 1 < h - 1) && (c - 1 < w - 1);

        mag = 0;
        if (inner)
        begin
            if (mode_reg == gem_pkg::OP_ROBERTS)
            begin
                gx = win_px[0] - win_px[4];
                gy = win_px[1] - win_px[3];
            end
            else
            begin
                // unused mode falls through to Sobel weights
                k  = (mode_reg == gem_pkg::OP_PREWITT) ? 1 : 2;
                gx = win_px[0] + k*win_px[3] + win_px[6]
                   - win_px[2] - k*win_px[5] - win_px[8];
                gy = win_px[0] + k*win_px[1] + win_px[2]
                   - win_px[6] - k*win_px[7] - win_px[8];
            end
            mag = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
            if (mag > int'(gem_pkg::EDGE_MAX)) mag = int'(gem_pkg::EDGE_MAX);
        end

        row_end = (c >= w - 1);
        res.last = row_end && (r >= h - 1);
        if (row_end)
        begin
            next_col = 0;
            next_row = res.last ? 0 : r + 1;
        end
        else
        begin
            next_col = c + 1;
        end

        res.edge_val  = 8'(mag);
        res.pos_valid = pos_ok;
        return res;
    endfunction

    task automatic note_failure(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("%s", msg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        edge_result_t got;
        edge_result_t want;

        if (!rst_n)
        begin
            mode_reg   = gem_pkg::OP_ROBERTS;
            width_reg  = gem_pkg::WIDTH_RESET;
            height_reg = gem_pkg::HEIGHT_RESET;
            for (int i = 0; i < MAX_WIDTH; i++)
            begin
                upper_row[i]  = '0;
                middle_row[i] = '0;
            end
            for (int i = 0; i < 9; i++)
                win_px[i] = 0;
            next_col = 0;
            next_row = 0;
            pending_edges.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    gem_pkg::CFG_OPERATOR_MODE:
                        mode_reg = cfg_data[1:0];
                    gem_pkg::CFG_IMAGE_WIDTH:
                        width_reg = cfg_data[gem_pkg::WIDTH_REG_W-1:0];
                    gem_pkg::CFG_IMAGE_HEIGHT:
                        height_reg = cfg_data[gem_pkg::HEIGHT_REG_W-1:0];
                    default: ;
                endcase
            end

            if (in_valid && in_ready)
                pending_edges.push_back(predict_edge(pixel));

            if (out_valid && out_ready)
            begin
                got = {edge_value, position_valid, frame_last};
                if (pending_edges.size() == 0)
                begin
                    note_failure($sformatf(
                        "result %0d: unexpected transfer, edge %0d valid %0b last %0b",
                        result_idx, got.edge_val, got.pos_valid, got.last));
                end
                else
                begin
                    want = pending_edges.pop_front();
                    if (got !== want)
                        note_failure($sformatf({"result %0d: expected edge %0d valid %0b",
                                                " last %0b, got edge %0d valid %0b last %0b"},
                            result_idx, want.edge_val, want.pos_valid, want.last,
                            got.edge_val, got.pos_valid, got.last));
                end
                result_idx++;
            end
        end
        fail_count <= mismatch_cnt + pending_edges.size();
    end

endmodule

>>> tb/sv/gradient_edge_magnitude_core_tb.sv
// ----------------------------------------------------------------------------
// gradient_edge_magnitude_core_tb
// Stimulus and verdict for the gradient edge magnitude core.
// A narrow priming frame fills the line store columns that narrow frames use,
// then short directed frames hit saturation, the Sobel and Roberts operators,
// the unused mode code and degenerate sizes. Random frames with random
// configs follow under several idle/stall mixes, including a long output
// hold-off and a full drain mid-stream. Wide frames start from the first
// pixel of a frame so only row 0 touches columns that were never written.
// Checking is done by gem_edge_checker.
// ----------------------------------------------------------------------------
module gradient_edge_magnitude_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         CFG_DATA_W      = gem_pkg::CFG_DATA_W;
    localparam int         MAX_W           = 1024;
    localparam int         PRIME_W         = 32;
    localparam int         CLK_HALF        = 5;
    localparam int         HOLD_CYCLES     = 80;
    localparam int         TIMEOUT_NS      = 2_000_000;
    localparam logic [1:0] CFG_SPARE_INDEX = 2'd3;

    localparam logic [7:0] DIR_FRAMES [3][9] = '{
        '{8'd0,   8'd0,   8'd255, 8'd0,   8'd0,   8'd255, 8'd0,   8'd0,   8'd255},
        '{8'd255, 8'd255, 8'd255, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0},
        '{8'd255, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0}
    };
    localparam logic [CFG_DATA_W-1:0] DIR_MODES [3] = '{
        CFG_DATA_W'(gem_pkg::OP_SOBEL), 12'hFFF, CFG_DATA_W'(gem_pkg::OP_ROBERTS)
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [1:0]            cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [7:0]            pixel = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [7:0]            edge_value;
    logic                  position_valid;
    logic                  frame_last;
    int                    fail_count;

    int idle_pct = 0;
    int stall_pct = 0;
    int sent_cnt = 0;
    int recv_cnt = 0;
    int hold_seq = 0;
    int hold_seen = 0;
    int hold_left = 0;

    always #(CLK_HALF) clk = ~clk;

    gradient_edge_magnitude_core #(
        .MAX_WIDTH(MAX_W)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .pixel(pixel),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .edge_value(edge_value),
        .position_valid(position_valid),
        .frame_last(frame_last)
    );

    gem_edge_checker #(
        .MAX_WIDTH(MAX_W)
    ) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .pixel(pixel),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .edge_value(edge_value),
        .position_valid(position_valid),
        .frame_last(frame_last),
        .fail_count(fail_count)
    );

    // result side: random stall, or a long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
            hold_seen <= 0;
        end
        else if (hold_seq != hold_seen)
        begin
            hold_seen <= hold_seq;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (in_valid && in_ready)
            sent_cnt <= sent_cnt + 1;
        if (out_valid && out_ready)
            recv_cnt <= recv_cnt + 1;
    end

    task automatic cfg_write(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic push_pixel(input logic [7:0] p);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel    <= p;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (recv_cnt != sent_cnt)
            @(posedge clk);
    endtask

    function automatic logic [7:0] rand_pixel();
        case ($urandom_range(9))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // one pixel in a 1x1 frame puts the raster position back to the origin
    task automatic home_position();
        drain();
        cfg_write(gem_pkg::CFG_IMAGE_WIDTH, CFG_DATA_W'(1));
        cfg_write(gem_pkg::CFG_IMAGE_HEIGHT, CFG_DATA_W'(1));
        push_pixel(rand_pixel());
        drain();
    endtask

    task automatic random_frames(input int budget);
        int w_val;
        int h_val;
        int ew;
        int eh;
        int n;

        while (budget > 0)
        begin
            case ($urandom_range(19))
                0:       w_val = $urandom_range(2);
                1:       w_val = MAX_W;
                2:       w_val = $urandom_range(2047, MAX_W + 1);
                default: w_val = $urandom_range(20, 3);
            endcase
            case ($urandom_range(19))
                0:       h_val = $urandom_range(1);
                1:       h_val = 4095;
                2:       h_val = 2;
                default: h_val = $urandom_range(8, 3);
            endcase
            if (w_val > PRIME_W)
                home_position();
            else
                drain();
            cfg_write(gem_pkg::CFG_OPERATOR_MODE, CFG_DATA_W'($urandom_range(4095)));
            cfg_write(gem_pkg::CFG_IMAGE_WIDTH, {1'($urandom_range(1)), 11'(w_val)});
            cfg_write(gem_pkg::CFG_IMAGE_HEIGHT, CFG_DATA_W'(h_val));
            if ($urandom_range(9) == 0)
                cfg_write(CFG_SPARE_INDEX, CFG_DATA_W'($urandom_range(4095)));

            ew = (w_val == 0) ? 1 : ((w_val > MAX_W) ? MAX_W : w_val);
            eh = (h_val == 0) ? 1 : h_val;
            n = ew * eh;
            // partial frame leaves the position mid-image for the next config
            if ($urandom_range(4) == 0)
                n = $urandom_range(n, 1);
            if (n > 150)
                n = 150;
            repeat (n)
            begin
                if ($urandom_range(199) == 0)
                    drain();
                push_pixel(rand_pixel());
            end
            budget -= n;
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // priming frame: both line stores written in every narrow column
        cfg_write(gem_pkg::CFG_IMAGE_WIDTH, CFG_DATA_W'(PRIME_W));
        cfg_write(gem_pkg::CFG_IMAGE_HEIGHT, CFG_DATA_W'(3));
        repeat (3 * PRIME_W)
            push_pixel(rand_pixel());

        drain();
        cfg_write(gem_pkg::CFG_IMAGE_WIDTH, CFG_DATA_W'(3));
        for (int f = 0; f < 3; f++)
        begin
            drain();
            cfg_write(gem_pkg::CFG_OPERATOR_MODE, DIR_MODES[f]);
            for (int j = 0; j < 9; j++)
                push_pixel(DIR_FRAMES[f][j]);
        end

        // zero width and height behave as one pixel per frame
        drain();
        cfg_write(gem_pkg::CFG_IMAGE_WIDTH, CFG_DATA_W'(0));
        cfg_write(gem_pkg::CFG_IMAGE_HEIGHT, CFG_DATA_W'(0));
        repeat (4)
            push_pixel(rand_pixel());

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 68; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 68; end
                default: begin idle_pct = 9;  stall_pct = 9;  end
            endcase

            if (ph == 0)
            begin
                drain();
                cfg_write(gem_pkg::CFG_OPERATOR_MODE, CFG_DATA_W'(gem_pkg::OP_PREWITT));
                cfg_write(gem_pkg::CFG_IMAGE_WIDTH, CFG_DATA_W'(16));
                cfg_write(gem_pkg::CFG_IMAGE_HEIGHT, CFG_DATA_W'(8));
                hold_seq <= hold_seq + 1;
                for (int i = 0; i < 128; i++)
                begin
                    if (i == 96)
                        drain();
                    push_pixel(rand_pixel());
                end
            end

            random_frames(180);
        end

        drain();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Some tests failed");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/gem_pkg.sv
hw/rtl/gradient_edge_magnitude_core.sv
tb/sv/gem_edge_checker.sv
tb/sv/gradient_edge_magnitude_core_tb.sv
